[hdl/stid_pkg.sv]
package stid_pkg;

    localparam int unsigned LIFE_W = 46;
    localparam logic [29:0] NS_PER_SEC = 30'd1000000000;

    typedef enum logic [2:0] {
        OP_REGISTER = 3'd0,
        OP_REVOKE   = 3'd1,
        OP_BULK     = 3'd2,
        OP_FIND     = 3'd3,
        OP_TICK     = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_MISSING = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ADD,
        S_SCAN,
        S_FIN
    } t_state;

    typedef struct packed {
        logic [31:0] key_hi;
        logic [63:0] key_lo;
        logic [63:0] ino;
        logic [63:0] client;
        logic [1:0]  mode;
        logic [63:0] expire;
    } t_row;

    localparam int unsigned ROW_W = $bits(t_row);

endpackage

[hdl/stateid_trust_table_with_expiry_top.sv]
// Table of state identifiers with expiry. An operation is taken when start is high and busy is
// low; its single result appears for one cycle with o_done high and cannot be held off. Every
// operation sweeps all TABLE_ENTRIES slots of the entry memory, one read per cycle, and the
// result strobe follows the sweep; the next transfer can be taken in the cycle of that strobe.
// Valid bits are kept in flip-flops and cleared by reset, so no clearing pass is needed.
module stateid_trust_table_with_expiry_top
    import stid_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_opcode,
    input  logic [63:0] i_key_lo,
    input  logic [31:0] i_key_hi,
    input  logic [63:0] i_file_ino,
    input  logic [63:0] i_client_id,
    input  logic [1:0]  i_io_mode,
    input  logic [63:0] i_expire_time,
    input  logic [63:0] i_now_time,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic        o_hit,
    output logic [63:0] o_found_ino,
    output logic [63:0] o_found_client,
    output logic [1:0]  o_found_mode,
    output logic [63:0] o_found_expire,
    output logic [6:0]  o_removed_count,
    output logic [6:0]  o_renewed_count
);

    localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);

    t_state r_state, n_state;

    logic [15:0]         r_lease;
    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [CW-1:0]       r_idx;
    logic                r_rd_vld;
    logic [AW-1:0]       r_rd_idx;

    logic [2:0]          r_op;
    logic [63:0]         r_klo;
    logic [31:0]         r_khi;
    logic [63:0]         r_ino;
    logic [63:0]         r_client;
    logic [1:0]          r_mode;
    logic [63:0]         r_expire;
    logic [63:0]         r_now;
    logic [LIFE_W-1:0]   r_life;
    logic [63:0]         r_renew;

    logic                r_found;
    logic [AW-1:0]       r_fidx;
    t_row                r_row;
    logic                r_free;
    logic [AW-1:0]       r_free_idx;
    logic [6:0]          r_cnt_rm;
    logic [6:0]          r_cnt_rn;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    t_row                ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [ROW_W-1:0]    ram_q;
    t_row                q;

    logic                v;
    logic                kmatch;
    logic                e_nz;
    logic                e_le;
    logic [63:0]         diff;
    logic [63:0]         thresh;
    logic                expire_hit;
    logic                renew_hit;
    logic                bulk_hit;
    logic [64:0]         renew_sum;
    logic                scan_last;
    logic                accept;

    stid_ram #(
        .WIDTH(ROW_W),
        .DEPTH(TABLE_ENTRIES)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_q)
    );

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {16'd0, r_lease} : 32'd0;
    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    assign q          = t_row'(ram_q);
    assign v          = r_valid[r_rd_idx];
    assign kmatch     = v && (q.key_lo == r_klo) && (q.key_hi == r_khi);
    assign e_nz       = (q.expire != 64'd0);
    assign e_le       = (q.expire <= r_now);
    assign diff       = q.expire - r_now;
    assign thresh     = 64'(r_life >> 1);
    assign expire_hit = v && e_nz && e_le;
    assign renew_hit  = v && e_nz && !e_le && (diff < thresh);
    assign bulk_hit   = v && ((r_client == 64'd0) || (q.client == r_client));
    assign renew_sum  = {1'b0, r_now} + 65'(r_life);
    assign scan_last  = (r_idx == CW'(TABLE_ENTRIES));
    assign ram_raddr  = r_idx[AW-1:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (accept) n_state = S_MUL;
            S_MUL:  n_state = S_ADD;
            S_ADD:  n_state = S_SCAN;
            S_SCAN: if (scan_last) n_state = S_FIN;
            S_FIN:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_rd_idx;
        ram_wdata = q;
        unique case (r_state)
            S_SCAN: begin
                if (r_rd_vld && (t_op'(r_op) == OP_TICK) && renew_hit) begin
                    ram_we           = 1'b1;
                    ram_wdata.expire = r_renew;
                end
            end
            S_FIN: begin
                if (t_op'(r_op) == OP_REGISTER) begin
                    if (r_found) begin
                        ram_we           = 1'b1;
                        ram_waddr        = r_fidx;
                        ram_wdata        = r_row;
                        ram_wdata.expire = r_expire;
                        ram_wdata.mode   = r_mode;
                    end else if (r_free) begin
                        ram_we    = 1'b1;
                        ram_waddr = r_free_idx;
                        ram_wdata = '{key_hi: r_khi, key_lo: r_klo, ino: r_ino,
                                      client: r_client, mode: r_mode, expire: r_expire};
                    end
                end
            end
            default: ram_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_lease  <= 16'd90;
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
            o_done   <= 1'b0;
        end else begin
            r_state <= n_state;
            o_done  <= 1'b0;
            if (psel && penable && pwrite && paddr[2] == 1'b0) begin
                r_lease <= pwdata[15:0];
            end
            r_rd_vld <= (r_state == S_SCAN) && !scan_last;
            if (r_state == S_SCAN && r_rd_vld) begin
                if ((t_op'(r_op) == OP_BULK && bulk_hit)
                        || (t_op'(r_op) == OP_TICK && expire_hit)) begin
                    r_valid[r_rd_idx] <= 1'b0;
                end
            end
            if (r_state == S_FIN) begin
                o_done <= 1'b1;
                if (t_op'(r_op) == OP_REVOKE && r_found) begin
                    r_valid[r_fidx] <= 1'b0;
                end
                if (t_op'(r_op) == OP_REGISTER && !r_found && r_free) begin
                    r_valid[r_free_idx] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_idx[AW-1:0];
        unique case (r_state)
            S_IDLE: begin
                r_op     <= i_opcode;
                r_klo    <= i_key_lo;
                r_khi    <= i_key_hi;
                r_ino    <= i_file_ino;
                r_client <= i_client_id;
                r_mode   <= i_io_mode;
                r_expire <= i_expire_time;
                r_now    <= i_now_time;
            end
            S_MUL: begin
                r_life   <= LIFE_W'(r_lease * NS_PER_SEC);
                r_idx    <= '0;
                r_found  <= 1'b0;
                r_free   <= 1'b0;
                r_cnt_rm <= 7'd0;
                r_cnt_rn <= 7'd0;
            end
            S_ADD: begin
                r_renew <= renew_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : renew_sum[63:0];
            end
            S_SCAN: begin
                if (!scan_last) begin
                    r_idx <= r_idx + CW'(1);
                end
                if (r_rd_vld) begin
                    if (kmatch && !r_found) begin
                        r_found <= 1'b1;
                        r_fidx  <= r_rd_idx;
                        r_row   <= q;
                    end
                    if (!v && !r_free) begin
                        r_free     <= 1'b1;
                        r_free_idx <= r_rd_idx;
                    end
                    if ((t_op'(r_op) == OP_BULK && bulk_hit)
                            || (t_op'(r_op) == OP_TICK && expire_hit)) begin
                        if (r_cnt_rm != 7'd127) r_cnt_rm <= r_cnt_rm + 7'd1;
                    end
                    if (t_op'(r_op) == OP_TICK && renew_hit) begin
                        if (r_cnt_rn != 7'd127) r_cnt_rn <= r_cnt_rn + 7'd1;
                    end
                end
            end
            S_FIN: begin
                o_status        <= ST_OK;
                o_hit           <= 1'b0;
                o_found_ino     <= 64'd0;
                o_found_client  <= 64'd0;
                o_found_mode    <= 2'd0;
                o_found_expire  <= 64'd0;
                o_removed_count <= 7'd0;
                o_renewed_count <= 7'd0;
                unique case (t_op'(r_op))
                    OP_REGISTER: begin
                        o_hit <= r_found;
                        if (!r_found && !r_free) o_status <= ST_FULL;
                    end
                    OP_REVOKE: begin
                        o_hit <= r_found;
                        if (r_found) o_removed_count <= 7'd1;
                        else o_status <= ST_MISSING;
                    end
                    OP_BULK: o_removed_count <= r_cnt_rm;
                    OP_FIND: begin
                        o_hit <= r_found;
                        if (r_found) begin
                            o_found_ino    <= r_row.ino;
                            o_found_client <= r_row.client;
                            o_found_mode   <= r_row.mode;
                            o_found_expire <= r_row.expire;
                        end else begin
                            o_status <= ST_MISSING;
                        end
                    end
                    OP_TICK: begin
                        o_removed_count <= r_cnt_rm;
                        o_renewed_count <= r_cnt_rn;
                    end
                    default: o_hit <= 1'b0;
                endcase
            end
            default: r_idx <= r_idx;
        endcase
    end

endmodule

[hdl/stid_ram.sv]
module stid_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

[hdl/stid_chk.sv]
module stid_chk
    import stid_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_done,
    input logic [1:0] o_status,
    input logic       o_hit
);

    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after a transfer");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result without a pending operation");

    a_done_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("still busy while the result is shown");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_status == ST_OK || o_status == ST_FULL || o_status == ST_MISSING))
        else $error("bad status code");

    a_hit_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_hit) |-> (o_status == ST_OK))
        else $error("hit with an error status");

endmodule

bind stateid_trust_table_with_expiry_top stid_chk u_stid_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done),
    .o_status(o_status),
    .o_hit   (o_hit)
);
